[design/tmp_pkg.sv]
// ----------------------------------------------------------------------------
// tmp_pkg
// Shared types and constants for the trapezoidal motion profile core.
// ----------------------------------------------------------------------------
package tmp_pkg;

    // register field width and velocity ceiling
    localparam int REG_W = 31;
    localparam logic [30:0] VEL_MAX = 31'h7FFF_FFFF;

    // register indexes on the configuration port
    localparam logic [1:0] REG_VEL  = 2'd0;
    localparam logic [1:0] REG_ACC  = 2'd1;
    localparam logic [1:0] REG_DIST = 2'd2;

    // phase codes of a result item
    typedef enum logic [1:0] {
        PH_ACCEL  = 2'd0,
        PH_CRUISE = 2'd1,
        PH_DECEL  = 2'd2,
        PH_DONE   = 2'd3
    } t_phase;

    // profile setup sequencer
    typedef enum logic [2:0] {
        SEQ_SQUARE,
        SEQ_DACC,
        SEQ_TA,
        SEQ_TC,
        SEQ_TRI,
        SEQ_ROOT,
        SEQ_FINAL,
        SEQ_DONE
    } t_seq_state;

endpackage

[design/tmp_if.sv]
// ----------------------------------------------------------------------------
// tmp_if
// Valid/ready channels for sample items in and profile items out.
// ----------------------------------------------------------------------------
interface tmp_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] sample_time;

    modport source (output valid, output sample_time, input ready);
    modport sink   (input valid, input sample_time, output ready);
endinterface

interface tmp_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  phase;
    logic signed [31:0] accel_out;
    logic [30:0] vel_out;
    logic [30:0] pos_out;

    modport source (output valid, output phase, output accel_out, output vel_out,
                    output pos_out, input ready);
    modport sink   (input valid, input phase, input accel_out, input vel_out,
                    input pos_out, output ready);
endinterface

[design/tmp_setup.sv]
// ----------------------------------------------------------------------------
// tmp_setup
// Works out the phase boundary times of the profile from the registers with
// a shared bit-serial divider and a bit-pair square root.
// ----------------------------------------------------------------------------
module tmp_setup #(
    parameter int FRAC_BITS = 16
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_start,
    input  logic [30:0]            i_vel,
    input  logic [30:0]            i_acc,
    input  logic [30:0]            i_dist,
    output logic                   o_done,
    output logic [FRAC_BITS+32:0]  o_b1,
    output logic [FRAC_BITS+32:0]  o_b2,
    output logic [FRAC_BITS+32:0]  o_tend,
    output logic [30:0]            o_dh
);
    import tmp_pkg::*;

    localparam int F      = FRAC_BITS;
    localparam int TW     = F + 33;
    localparam int DW     = (2 * F + 31 > 62) ? 2 * F + 31 : 62;
    localparam int XW     = (DW > 65) ? DW : 65;
    localparam int CW     = $clog2(DW + 1);
    localparam int RSTEPS = 32;

    t_seq_state r_state, n_state;

    logic [DW-1:0] r_num;
    logic [30:0]   r_rem;
    logic [30:0]   r_den;
    logic [CW-1:0] r_cnt;
    logic [DW-1:0] r_dacc;
    logic          r_tri;
    logic [TW-1:0] r_ta, r_tc, r_b1, r_b2, r_tend;
    logic [30:0]   r_dh;
    logic [63:0]   r_rn, r_res, r_bit;
    logic [32:0]   r_tp;

    logic          w_div_done, w_root_done, w_div_run, w_root_run;
    logic [31:0]   w_rem2, w_rem_diff;
    logic          w_sub_ok;
    logic          w_fits, w_ovf;
    logic [XW-1:0] w_numx;
    logic [63:0]   w_trial;
    logic          w_take;
    logic [61:0]   w_sq;

    // divider and root step terms
    always_comb begin
        w_div_done  = (r_cnt == CW'(DW));
        w_root_done = (r_cnt == CW'(RSTEPS));
        w_rem2      = {r_rem, r_num[DW-1]};
        w_sub_ok    = (w_rem2 >= {1'b0, r_den});
        w_rem_diff  = w_rem2 - {1'b0, r_den};
        w_fits      = (r_num <= DW'(i_dist));
        w_numx      = XW'(r_num);
        w_ovf       = (w_numx >= (XW'(1) << 64));
        w_trial     = r_res + r_bit;
        w_take      = (r_rn >= w_trial);
        w_sq        = {31'b0, i_vel} * {31'b0, i_vel};
    end

    // next state
    always_comb begin
        n_state = r_state;
        if (i_start) begin
            n_state = SEQ_SQUARE;
        end else begin
            case (r_state)
                SEQ_SQUARE: n_state = SEQ_DACC;
                SEQ_DACC: begin
                    if (w_div_done) n_state = w_fits ? SEQ_TA : SEQ_TRI;
                end
                SEQ_TA:     if (w_div_done) n_state = SEQ_TC;
                SEQ_TC:     if (w_div_done) n_state = SEQ_FINAL;
                SEQ_TRI: begin
                    if (w_div_done) n_state = w_ovf ? SEQ_FINAL : SEQ_ROOT;
                end
                SEQ_ROOT:   if (w_root_done) n_state = SEQ_FINAL;
                SEQ_FINAL:  n_state = SEQ_DONE;
                SEQ_DONE:   n_state = SEQ_DONE;
                default:    n_state = SEQ_SQUARE;
            endcase
        end
    end

    // sequencer outputs
    always_comb begin
        o_done     = (r_state == SEQ_DONE);
        w_div_run  = (r_state inside {SEQ_DACC, SEQ_TA, SEQ_TC, SEQ_TRI}) && !w_div_done;
        w_root_run = (r_state == SEQ_ROOT) && !w_root_done;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= SEQ_SQUARE;
        end else begin
            r_state <= n_state;
        end
    end

    // divider, root and boundary datapath
    always_ff @(posedge i_clk) begin
        if (w_div_run) begin
            r_rem <= w_sub_ok ? w_rem_diff[30:0] : w_rem2[30:0];
            r_num <= {r_num[DW-2:0], w_sub_ok};
            r_cnt <= CW'(r_cnt + 1'b1);
        end else if (w_root_run) begin
            if (w_take) begin
                r_rn  <= r_rn - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
            r_cnt <= CW'(r_cnt + 1'b1);
        end else begin
            case (r_state)
                SEQ_SQUARE: begin
                    r_num <= DW'(w_sq);
                    r_den <= i_acc;
                    r_rem <= '0;
                    r_cnt <= '0;
                end
                SEQ_DACC: begin
                    r_dacc <= r_num;
                    r_tri  <= !w_fits;
                    r_den  <= i_acc;
                    r_rem  <= '0;
                    r_cnt  <= '0;
                    if (w_fits) begin
                        r_num <= DW'(i_vel) << F;
                    end else begin
                        r_num <= DW'(i_dist) << (2 * F);
                    end
                end
                SEQ_TA: begin
                    r_ta  <= TW'(r_num);
                    r_num <= DW'(i_dist - r_dacc[30:0]) << F;
                    r_den <= i_vel;
                    r_rem <= '0;
                    r_cnt <= '0;
                end
                SEQ_TC: begin
                    r_tc <= TW'(r_num);
                end
                SEQ_TRI: begin
                    if (w_ovf) begin
                        r_tp <= 33'h1_0000_0000;
                    end else begin
                        r_rn  <= w_numx[63:0];
                        r_res <= '0;
                        r_bit <= 64'h4000_0000_0000_0000;
                        r_cnt <= '0;
                    end
                end
                SEQ_ROOT: begin
                    r_tp <= r_res[32:0];
                end
                SEQ_FINAL: begin
                    r_dh <= r_dacc[31:1];
                    if (r_tri) begin
                        r_b1   <= TW'(r_tp);
                        r_b2   <= TW'(r_tp);
                        r_tend <= TW'({r_tp, 1'b0});
                    end else begin
                        r_b1   <= r_ta;
                        r_b2   <= r_ta + r_tc;
                        r_tend <= (r_ta << 1) + r_tc;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_b1   = r_b1;
    assign o_b2   = r_b2;
    assign o_tend = r_tend;
    assign o_dh   = r_dh;

endmodule

[design/trapezoid_motion_profile_core.sv]
// ----------------------------------------------------------------------------
// trapezoid_motion_profile_core
// Evaluates a trapezoidal (or triangular) velocity profile at time samples.
// ----------------------------------------------------------------------------
// Usage: peak velocity, acceleration and travel distance are written over the
// APB port (byte addresses 0, 4, 8); writes to other addresses are ignored.
// Each item on i_sample carries a Q time since the start of the move; each
// item on o_result carries phase, acceleration, velocity and position.
// After reset and after every register write the setup unit works out the
// phase boundaries with a bit-serial divider and square root; i_sample.ready
// stays low meanwhile. Registers must only be rewritten while no item is in
// flight; the block itself does not enforce it. Once set up, one item is
// accepted every cycle unless o_result stalls, and each result passes
// through a five-stage pipeline with two multiply stages. When o_result is
// stalled the whole pipeline holds and i_sample.ready drops only once the
// output register is full, so nothing is lost or repeated. Reset empties
// the pipeline and reloads register defaults.
// ----------------------------------------------------------------------------
module trapezoid_motion_profile_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tmp_in_if.sink      i_sample,
    tmp_out_if.source   o_result,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import tmp_pkg::*;

    localparam int F   = FRAC_BITS;
    localparam int TW  = F + 33;
    localparam int HW  = TW - 32;
    localparam int PLW = 63;
    localparam int PHW = 31 + HW;
    localparam int PW  = 31 + TW;
    localparam int SW  = PW - F;

    // configuration registers
    logic [30:0] r_vel, r_acc, r_dist;
    logic        w_wr, w_start;
    logic [30:0] w_vel, w_acc;

    // setup results
    logic          w_ready_cfg;
    logic [TW-1:0] w_b1, w_b2, w_tend;
    logic [30:0]   w_dh;

    // pipeline
    logic           w_en;
    logic [TW-1:0]  w_t;
    t_phase         w_ph;
    logic [TW-1:0]  w_m;
    logic           r1_vld, r2_vld, r3_vld, r4_vld, r5_vld;
    t_phase         r1_ph, r2_ph, r3_ph, r4_ph, r5_ph;
    logic [TW-1:0]  r1_m, r2_m, r3_m;
    logic [PLW-1:0] r2_plo, r4_qlo;
    logic [PHW-1:0] r2_phi, r4_qhi;
    logic [30:0]    w_k;
    logic [PW-1:0]  w_prod;
    logic [SW-1:0]  w_sh;
    logic [30:0]    w_vel3;
    logic [30:0]    r3_vel, r4_vel, r5_vel;
    logic [SW-1:0]  r3_sh;
    logic [SW:0]    w_csum;
    logic [30:0]    r4_cpos;
    logic [PW-1:0]  w_q, w_drop;
    logic [30:0]    w_pos5;
    logic [31:0]    w_acc5;
    logic [31:0]    r5_acc;
    logic [30:0]    r5_pos;

    // apb write and readback
    assign pready  = 1'b1;
    assign w_wr    = psel && penable && pwrite;
    assign w_start = w_wr && (paddr[3:2] == REG_VEL || paddr[3:2] == REG_ACC
                              || paddr[3:2] == REG_DIST);

    always_comb begin
        case (paddr[3:2])
            REG_VEL:  prdata = {1'b0, r_vel};
            REG_ACC:  prdata = {1'b0, r_acc};
            REG_DIST: prdata = {1'b0, r_dist};
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vel  <= 31'(1) << F;
            r_acc  <= 31'(1) << F;
            r_dist <= '0;
        end else if (w_wr) begin
            case (paddr[3:2])
                REG_VEL:  r_vel  <= pwdata[30:0];
                REG_ACC:  r_acc  <= pwdata[30:0];
                REG_DIST: r_dist <= pwdata[30:0];
                default:  ;
            endcase
        end
    end

    // a zero limit acts as the smallest step
    assign w_vel = (r_vel == '0) ? 31'd1 : r_vel;
    assign w_acc = (r_acc == '0) ? 31'd1 : r_acc;

    tmp_setup #(
        .FRAC_BITS (FRAC_BITS)
    ) u_setup (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_vel   (w_vel),
        .i_acc   (w_acc),
        .i_dist  (r_dist),
        .o_done  (w_ready_cfg),
        .o_b1    (w_b1),
        .o_b2    (w_b2),
        .o_tend  (w_tend),
        .o_dh    (w_dh)
    );

    // pipeline advances unless the output item is held
    assign w_en           = !r5_vld || o_result.ready;
    assign i_sample.ready = w_en && w_ready_cfg;

    // stage 1: phase and multiplier operand
    always_comb begin
        w_t = TW'(i_sample.sample_time);
        if (w_t < w_b1) begin
            w_ph = PH_ACCEL;
            w_m  = w_t;
        end else if (w_t < w_b2) begin
            w_ph = PH_CRUISE;
            w_m  = w_t - w_b1;
        end else if (w_t < w_tend) begin
            w_ph = PH_DECEL;
            w_m  = w_tend - w_t;
        end else begin
            w_ph = PH_DONE;
            w_m  = '0;
        end
    end

    // stage 2 rate term, stage 3 velocity
    assign w_k    = (r1_ph == PH_CRUISE) ? w_vel : w_acc;
    assign w_prod = PW'(r2_plo) + (PW'(r2_phi) << 32);
    assign w_sh   = SW'(w_prod >> F);

    always_comb begin
        case (r2_ph)
            PH_ACCEL, PH_DECEL: w_vel3 = (w_sh > SW'(VEL_MAX)) ? VEL_MAX : w_sh[30:0];
            PH_CRUISE:          w_vel3 = w_vel;
            default:            w_vel3 = '0;
        endcase
    end

    // stage 4 cruise position
    assign w_csum = (SW + 1)'(r3_sh) + (SW + 1)'(w_dh);

    // stage 5 ramp position and acceleration
    assign w_q    = PW'(r4_qlo) + (PW'(r4_qhi) << 32);
    assign w_drop = w_q >> (F + 1);

    always_comb begin
        case (r4_ph)
            PH_ACCEL: begin
                w_pos5 = (w_drop > PW'(r_dist)) ? r_dist : w_drop[30:0];
                w_acc5 = {1'b0, w_acc};
            end
            PH_CRUISE: begin
                w_pos5 = r4_cpos;
                w_acc5 = '0;
            end
            PH_DECEL: begin
                w_pos5 = (w_drop > PW'(r_dist)) ? '0 : r_dist - w_drop[30:0];
                w_acc5 = 32'd0 - {1'b0, w_acc};
            end
            default: begin
                w_pos5 = r_dist;
                w_acc5 = '0;
            end
        endcase
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
            r4_vld <= 1'b0;
            r5_vld <= 1'b0;
        end else if (w_en) begin
            r1_vld <= i_sample.valid && w_ready_cfg;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
            r4_vld <= r3_vld;
            r5_vld <= r4_vld;
        end
    end

    // stage payloads
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_ph   <= w_ph;
            r1_m    <= w_m;
            r2_ph   <= r1_ph;
            r2_m    <= r1_m;
            r2_plo  <= PLW'(w_k) * PLW'(r1_m[31:0]);
            r2_phi  <= PHW'(w_k) * PHW'(r1_m[TW-1:32]);
            r3_ph   <= r2_ph;
            r3_m    <= r2_m;
            r3_vel  <= w_vel3;
            r3_sh   <= w_sh;
            r4_ph   <= r3_ph;
            r4_vel  <= r3_vel;
            r4_qlo  <= PLW'(r3_vel) * PLW'(r3_m[31:0]);
            r4_qhi  <= PHW'(r3_vel) * PHW'(r3_m[TW-1:32]);
            r4_cpos <= (w_csum > (SW + 1)'(r_dist)) ? r_dist : w_csum[30:0];
            r5_ph   <= r4_ph;
            r5_vel  <= r4_vel;
            r5_acc  <= w_acc5;
            r5_pos  <= w_pos5;
        end
    end

    assign o_result.valid     = r5_vld;
    assign o_result.phase     = 2'(r5_ph);
    assign o_result.accel_out = r5_acc;
    assign o_result.vel_out   = r5_vel;
    assign o_result.pos_out   = r5_pos;

    // checks
    a_done_at_target : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && r5_ph == PH_DONE |->
            o_result.vel_out == '0 && o_result.pos_out == r_dist)
        else $error("done item not at rest at the target");

    a_pos_in_range : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> o_result.pos_out <= r_dist)
        else $error("position beyond travel distance");

    a_cruise_speed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid && r5_ph == PH_CRUISE |->
            o_result.vel_out == w_vel && o_result.accel_out == '0)
        else $error("cruise item off peak velocity");

    a_setup_blocks : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> !i_sample.ready)
        else $error("item taken while profile setup runs");

endmodule

[tb/tb_top.sv]
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the trapezoidal motion profile core. Profile registers are
// written over the APB port while the core is idle, and time samples are
// streamed through the valid/ready channels with random gaps and stalls.
// Every result item is checked field by field against a bit-exact profile
// evaluator kept here in step with the register settings.
// ----------------------------------------------------------------------------
module tb_top;
    import tmp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int          FB          = 16;
    localparam int          CYCLE_LIMIT = 600000;
    localparam logic [63:0] VEL_CEIL    = 64'h7FFF_FFFF;
    localparam logic [63:0] T_MAX       = 64'hFFFF_FFFF;
    localparam logic [3:0]  ADDR_UNUSED = 4'd12;

    typedef struct packed {
        t_phase             phase;
        logic signed [31:0] accel;
        logic [30:0]        vel;
        logic [30:0]        pos;
    } t_profile_pt;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    tmp_in_if  sample_ch ();
    tmp_out_if result_ch ();

    // profile registers as the core should hold them
    logic [30:0] prof_vel;
    logic [30:0] prof_acc;
    logic [30:0] prof_dist;

    t_profile_pt expected_pts[$];
    int          mismatches = 0;
    int          cycle_cnt = 0;
    bit          no_idle = 1'b0;
    int          hold_req = 0;
    int          hold_left = 0;

    trapezoid_motion_profile_core #(.FRAC_BITS(FB)) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch.sink),
        .o_result (result_ch.source),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #4 i_clk = ~i_clk;

    initial begin
        sample_ch.valid = 1'b0;
        sample_ch.sample_time = '0;
        result_ch.ready = 1'b0;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // integer square root, floor
    function automatic logic [63:0] int_sqrt(logic [63:0] n);
        logic [63:0] res;
        logic [63:0] bitv;
        res = '0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (n >= res + bitv) begin
                n = n - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // phase boundaries: end of ramp up, end of cruise, end of move
    function automatic void profile_bounds(output logic [63:0] t_up, output logic [63:0] t_cr,
                                           output logic [63:0] t_end, output logic [63:0] dacc);
        logic [63:0] v, a, d, ta, tc, q1, r1, tp;
        v = (prof_vel == 0) ? 64'd1 : 64'(prof_vel);
        a = (prof_acc == 0) ? 64'd1 : 64'(prof_acc);
        d = 64'(prof_dist);
        dacc = (v * v) / a;
        if (dacc <= d) begin
            ta = (v << FB) / a;
            tc = ((d - dacc) << FB) / v;
            t_up = ta;
            t_cr = ta + tc;
            t_end = 2 * ta + tc;
        end else begin
            q1 = (d << FB) / a;
            r1 = (d << FB) % a;
            if ((q1 >> (64 - FB)) != 0)
                tp = 64'd1 << 32;
            else
                tp = int_sqrt((q1 << FB) + ((r1 << FB) / a));
            t_up = tp;
            t_cr = tp;
            t_end = 2 * tp;
        end
    endfunction

    // commanded point of the profile at one time sample
    function automatic t_profile_pt eval_profile(logic [31:0] ts);
        t_profile_pt pt;
        logic [63:0] t_up, t_cr, t_end, dacc, a, d, t, r, v, p, drop;
        profile_bounds(t_up, t_cr, t_end, dacc);
        a = (prof_acc == 0) ? 64'd1 : 64'(prof_acc);
        d = 64'(prof_dist);
        t = 64'(ts);
        if (t < t_up) begin
            pt.phase = PH_ACCEL;
            pt.accel = a[31:0];
            v = (a * t) >> FB;
            if (v > VEL_CEIL) v = VEL_CEIL;
            p = (v * t) >> (FB + 1);
            if (p > d) p = d;
        end else if (t < t_cr) begin
            pt.phase = PH_CRUISE;
            pt.accel = '0;
            v = (prof_vel == 0) ? 64'd1 : 64'(prof_vel);
            p = dacc / 2 + ((v * (t - t_up)) >> FB);
            if (p > d) p = d;
        end else if (t < t_end) begin
            pt.phase = PH_DECEL;
            pt.accel = -$signed(a[31:0]);
            r = t_end - t;
            v = (a * r) >> FB;
            if (v > VEL_CEIL) v = VEL_CEIL;
            drop = (v * r) >> (FB + 1);
            p = (drop > d) ? 64'd0 : d - drop;
        end else begin
            pt.phase = PH_DONE;
            pt.accel = '0;
            v = 0;
            p = d;
        end
        pt.vel = v[30:0];
        pt.pos = p[30:0];
        return pt;
    endfunction

    // long receiver hold, counted down in cycles
    always @(posedge i_clk) begin
        if (hold_req > 0) begin
            hold_left <= hold_req;
            hold_req <= 0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // result side: check each item, then decide ready for the next edge
    always @(posedge i_clk) begin
        t_profile_pt exp_pt;
        if (i_rst_n && result_ch.valid && result_ch.ready) begin
            if (expected_pts.size() == 0) begin
                $error("unexpected result item: phase %0d", result_ch.phase);
                mismatches++;
            end else begin
                exp_pt = expected_pts.pop_front();
                if (result_ch.phase !== exp_pt.phase) begin
                    $error("phase: expected %0d, got %0d", exp_pt.phase, result_ch.phase);
                    mismatches++;
                end
                if (result_ch.accel_out !== exp_pt.accel) begin
                    $error("accel_out: expected %0d, got %0d", exp_pt.accel,
                           result_ch.accel_out);
                    mismatches++;
                end
                if (result_ch.vel_out !== exp_pt.vel) begin
                    $error("vel_out: expected %0d, got %0d", exp_pt.vel, result_ch.vel_out);
                    mismatches++;
                end
                if (result_ch.pos_out !== exp_pt.pos) begin
                    $error("pos_out: expected %0d, got %0d", exp_pt.pos, result_ch.pos_out);
                    mismatches++;
                end
            end
        end
        if (hold_left > 0) begin
            result_ch.ready <= 1'b0;
        end else begin
            result_ch.ready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 9);
        end
    end

    // one APB write: setup cycle then access cycle
    task automatic apb_write(logic [3:0] addr, logic [31:0] data);
        @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= addr;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // wait until every result is back and the pipeline has drained
    task automatic wait_drained();
        while (expected_pts.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    task automatic load_profile(logic [30:0] v, logic [30:0] a, logic [30:0] d);
        wait_drained();
        apb_write({REG_VEL, 2'b00}, {1'b0, v});
        apb_write({REG_ACC, 2'b00}, {1'b0, a});
        apb_write({REG_DIST, 2'b00}, {1'b0, d});
        prof_vel = v;
        prof_acc = a;
        prof_dist = d;
    endtask

    // send one sample item, with an occasional one-cycle gap before it
    task automatic send_sample(logic [31:0] ts);
        if (!no_idle && $urandom_range(0, 99) < 9) begin
            sample_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.sample_time <= ts;
        @(posedge i_clk);
        while (!sample_ch.ready) @(posedge i_clk);
        expected_pts.push_back(eval_profile(ts));
    endtask

    task automatic stop_sending();
        sample_ch.valid <= 1'b0;
    endtask

    // samples on either side of a phase boundary
    task automatic send_around(logic [63:0] b);
        if (b >= 1 && b - 1 <= T_MAX) send_sample(32'(b - 1));
        if (b <= T_MAX) send_sample(32'(b));
        if (b + 1 <= T_MAX) send_sample(32'(b + 1));
    endtask

    task automatic send_bounds();
        logic [63:0] t_up, t_cr, t_end, dacc;
        profile_bounds(t_up, t_cr, t_end, dacc);
        send_around(t_up);
        if (t_cr != t_up) send_around(t_cr);
        send_around(t_end);
    endtask

    // reset values: zero distance gives a move that is done at once
    task automatic test_reset_profile();
        prof_vel = 31'h0001_0000;
        prof_acc = 31'h0001_0000;
        prof_dist = '0;
        send_sample(32'd0);
        send_sample(32'hFFFF_FFFF);
        stop_sending();
        wait_drained();
        // writes to an unused address change nothing
        apb_write(ADDR_UNUSED, 32'h1234_5678);
        send_sample(32'd1);
        stop_sending();
    endtask

    // zero distance with V*V < A: ramps run with position held at zero
    task automatic test_zero_distance_ramp();
        load_profile(31'd46340, 31'h7FFF_FFFF, 31'd0);
        send_sample(32'd700);
        send_bounds();
        stop_sending();
    endtask

    // zero velocity and acceleration registers act as one
    task automatic test_zero_limits();
        load_profile(31'd0, 31'd0, 31'd1000);
        send_sample(32'd0);
        send_bounds();
        stop_sending();
    endtask

    // register extremes, saturated velocity and huge triangle
    task automatic test_register_extremes();
        load_profile(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
        send_bounds();
        stop_sending();
        load_profile(31'h7FFF_FFFF, 31'd1, 31'h7FFF_FFFF);
        send_sample(32'h8000_0000);
        send_sample(32'hFFFF_FFFF);
        stop_sending();
    endtask

    task automatic random_profile();
        logic [30:0] v, a, d;
        case ($urandom_range(0, 5))
            0: begin
                v = 31'($urandom);
                a = 31'($urandom);
                d = 31'($urandom);
            end
            1: begin
                v = 31'($urandom >> $urandom_range(1, 24));
                a = 31'($urandom >> $urandom_range(1, 24));
                d = '0;
            end
            default: begin
                v = 31'($urandom >> $urandom_range(1, 22));
                a = 31'($urandom >> $urandom_range(1, 22));
                d = 31'($urandom >> $urandom_range(1, 16));
            end
        endcase
        load_profile(v, a, d);
    endtask

    task automatic random_samples(int n);
        logic [63:0] t_up, t_cr, t_end, dacc, span;
        profile_bounds(t_up, t_cr, t_end, dacc);
        span = t_end + t_end / 8 + 4;
        if (span > T_MAX) span = T_MAX;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0: send_sample($urandom);
                1: send_around(($urandom_range(0, 2) == 0) ? t_up :
                               ($urandom_range(0, 1) == 0) ? t_cr : t_end);
                default: send_sample($urandom_range(0, 32'(span)));
            endcase
        end
        stop_sending();
    endtask

    // random profiles with samples spread over each move
    task automatic test_random_profiles(int n_profiles, int per_profile);
        for (int k = 0; k < n_profiles; k++) begin
            random_profile();
            random_samples(per_profile);
        end
    endtask

    // receiver holds off for a long stretch while items keep coming
    task automatic test_output_stall();
        random_profile();
        no_idle = 1'b1;
        hold_req = 300;
        random_samples(60);
        no_idle = 1'b0;
    endtask

    initial begin
        prof_vel = 31'h0001_0000;
        prof_acc = 31'h0001_0000;
        prof_dist = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_profile();
        test_zero_distance_ramp();
        test_zero_limits();
        test_register_extremes();
        test_random_profiles(14, 45);
        no_idle = 1'b1;
        test_random_profiles(2, 60);
        no_idle = 1'b0;
        test_output_stall();
        test_random_profiles(14, 45);

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

[filelist.f]
design/tmp_pkg.sv
design/tmp_if.sv
design/tmp_setup.sv
design/trapezoid_motion_profile_core.sv
tb/tb_top.sv
